// ----- src/segi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg
// Types and widths shared by the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

    localparam int CW  = 16;          // coordinate width
    localparam int DW  = 2*CW + 2;    // determinant and divider remainder
    localparam int CAW = 2*CW + 1;    // line constants x1*y2 - y1*x2
    localparam int NW  = 3*CW + 2;    // intersection numerators
    localparam int QW  = CW + 1;      // quotient magnitude bits produced

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic   hit;
        t_coord hit_x;
        t_coord hit_y;
    } t_seg_out;

    // intersection of both bounding boxes
    typedef struct packed {
        t_coord lox;
        t_coord hix;
        t_coord loy;
        t_coord hiy;
    } t_box;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [DW-1:0] den;
        t_box                 box;
    } t_num;

    typedef struct packed {
        logic [DW-1:0] ud;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [QW-1:0] lx;
        logic [QW-1:0] ly;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic          fx;
        logic          fy;
        logic          ovf;
        t_box          box;
    } t_div_st;

    typedef struct packed {
        logic signed [QW:0] px;
        logic signed [QW:0] py;
        logic               ovf;
        t_box               box;
    } t_quot;

endpackage

// ----- src/segi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_front
// Four pipeline stages that form the determinant and both numerators.
// ----------------------------------------------------------------------------
module segi_front
    import segi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_seg_in i_seg,
    output logic    o_vld,
    output t_num    o_num
);

    localparam int DFW = CW + 1;
    localparam int PW  = 2*CW;
    localparam int PDW = 2*DFW;

    function automatic t_coord f_min(input t_coord a, input t_coord b);
        f_min = (a < b) ? a : b;
    endfunction

    function automatic t_coord f_max(input t_coord a, input t_coord b);
        f_max = (a < b) ? b : a;
    endfunction

    logic [3:0] r_vld;

    // stage 1
    logic signed [DFW-1:0] n_dxa, n_dya, n_dxb, n_dyb;
    logic signed [PDW-1:0] n_pd1, n_pd2;
    logic signed [PW-1:0]  n_pa1, n_pa2, n_pb1, n_pb2;
    t_box                  n_box;

    logic signed [DFW-1:0] r1_dxa, r1_dya, r1_dxb, r1_dyb;
    logic signed [PDW-1:0] r1_pd1, r1_pd2;
    logic signed [PW-1:0]  r1_pa1, r1_pa2, r1_pb1, r1_pb2;
    t_box                  r1_box;

    // stage 2
    logic signed [DFW-1:0] r2_dxa, r2_dya, r2_dxb, r2_dyb;
    logic signed [CAW-1:0] r2_ca, r2_cb;
    logic signed [DW-1:0]  r2_den;
    t_box                  r2_box;

    // stage 3
    logic signed [NW-1:0]  r3_pxa, r3_pxb, r3_pya, r3_pyb;
    logic signed [DW-1:0]  r3_den;
    t_box                  r3_box;

    // stage 4
    t_num                  r4_num;

    assign n_dxa = DFW'(i_seg.a_start_x) - DFW'(i_seg.a_end_x);
    assign n_dya = DFW'(i_seg.a_start_y) - DFW'(i_seg.a_end_y);
    assign n_dxb = DFW'(i_seg.b_start_x) - DFW'(i_seg.b_end_x);
    assign n_dyb = DFW'(i_seg.b_start_y) - DFW'(i_seg.b_end_y);

    assign n_pd1 = PDW'(n_dxa) * PDW'(n_dyb);
    assign n_pd2 = PDW'(n_dya) * PDW'(n_dxb);
    assign n_pa1 = PW'(i_seg.a_start_x) * PW'(i_seg.a_end_y);
    assign n_pa2 = PW'(i_seg.a_start_y) * PW'(i_seg.a_end_x);
    assign n_pb1 = PW'(i_seg.b_start_x) * PW'(i_seg.b_end_y);
    assign n_pb2 = PW'(i_seg.b_start_y) * PW'(i_seg.b_end_x);

    assign n_box.lox = f_max(f_min(i_seg.a_start_x, i_seg.a_end_x),
                             f_min(i_seg.b_start_x, i_seg.b_end_x));
    assign n_box.hix = f_min(f_max(i_seg.a_start_x, i_seg.a_end_x),
                             f_max(i_seg.b_start_x, i_seg.b_end_x));
    assign n_box.loy = f_max(f_min(i_seg.a_start_y, i_seg.a_end_y),
                             f_min(i_seg.b_start_y, i_seg.b_end_y));
    assign n_box.hiy = f_min(f_max(i_seg.a_start_y, i_seg.a_end_y),
                             f_max(i_seg.b_start_y, i_seg.b_end_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dxa <= n_dxa;
            r1_dya <= n_dya;
            r1_dxb <= n_dxb;
            r1_dyb <= n_dyb;
            r1_pd1 <= n_pd1;
            r1_pd2 <= n_pd2;
            r1_pa1 <= n_pa1;
            r1_pa2 <= n_pa2;
            r1_pb1 <= n_pb1;
            r1_pb2 <= n_pb2;
            r1_box <= n_box;

            r2_dxa <= r1_dxa;
            r2_dya <= r1_dya;
            r2_dxb <= r1_dxb;
            r2_dyb <= r1_dyb;
            r2_ca  <= CAW'(r1_pa1) - CAW'(r1_pa2);
            r2_cb  <= CAW'(r1_pb1) - CAW'(r1_pb2);
            r2_den <= DW'(r1_pd1) - DW'(r1_pd2);
            r2_box <= r1_box;

            r3_pxa <= NW'(r2_ca) * NW'(r2_dxb);
            r3_pxb <= NW'(r2_dxa) * NW'(r2_cb);
            r3_pya <= NW'(r2_ca) * NW'(r2_dyb);
            r3_pyb <= NW'(r2_dya) * NW'(r2_cb);
            r3_den <= r2_den;
            r3_box <= r2_box;

            r4_num.nx  <= r3_pxa - r3_pxb;
            r4_num.ny  <= r3_pya - r3_pyb;
            r4_num.den <= r3_den;
            r4_num.box <= r3_box;
        end
    end

    assign o_vld = r_vld[3];
    assign o_num = r4_num;

endmodule

// ----- src/segi_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_div_step
// One restoring division step for the x and y lanes, one quotient bit each.
// ----------------------------------------------------------------------------
module segi_div_step
    import segi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_div_st i_st,
    output logic    o_vld,
    output t_div_st o_st
);

    logic [DW:0] n_tx, n_ty;
    logic        n_bx, n_by;
    t_div_st     n_st;
    logic        r_vld;
    t_div_st     r_st;

    assign n_tx = {i_st.rx, i_st.lx[QW-1]};
    assign n_ty = {i_st.ry, i_st.ly[QW-1]};
    assign n_bx = (n_tx >= {1'b0, i_st.ud});
    assign n_by = (n_ty >= {1'b0, i_st.ud});

    always_comb begin
        n_st    = i_st;
        // no subtract means the partial remainder is below the divisor, top bit clear
        n_st.rx = n_bx ? DW'(n_tx - {1'b0, i_st.ud}) : DW'(n_tx);
        n_st.ry = n_by ? DW'(n_ty - {1'b0, i_st.ud}) : DW'(n_ty);
        n_st.lx = {i_st.lx[QW-2:0], 1'b0};
        n_st.ly = {i_st.ly[QW-2:0], 1'b0};
        n_st.qx = {i_st.qx[QW-2:0], n_bx};
        n_st.qy = {i_st.qy[QW-2:0], n_by};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ----- src/segi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_div
// Pipelined signed division of both numerators by the determinant.
// Only the quotient bits that can land inside a coordinate box are produced;
// a larger quotient or a zero determinant raises the overflow flag.
// ----------------------------------------------------------------------------
module segi_div
    import segi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_num  i_num,
    output logic  o_vld,
    output t_quot o_quot
);

    // magnitude stage
    logic          ra_vld;
    logic [NW-1:0] ra_ux, ra_uy;
    logic [DW-1:0] ra_ud;
    logic          ra_fx, ra_fy;
    t_box          ra_box;

    logic [NW-1:0] n_ux, n_uy;
    logic [DW-1:0] n_ud;

    // setup stage and step chain
    logic          rb_vld;
    t_div_st       rb_st;
    t_div_st       n_st;
    logic [QW:0]   w_vld;
    t_div_st       w_st [QW+1];

    // sign stage
    logic          rc_vld;
    t_quot         rc_quot;
    t_quot         n_quot;

    assign n_ux = i_num.nx[NW-1] ? NW'(-i_num.nx) : NW'(i_num.nx);
    assign n_uy = i_num.ny[NW-1] ? NW'(-i_num.ny) : NW'(i_num.ny);
    assign n_ud = i_num.den[DW-1] ? DW'(-i_num.den) : DW'(i_num.den);

    // high part at or above the divisor: quotient too large to fit,
    // which also catches a zero determinant
    always_comb begin
        n_st     = '0;
        n_st.ud  = ra_ud;
        n_st.rx  = DW'(ra_ux[NW-1:QW]);
        n_st.ry  = DW'(ra_uy[NW-1:QW]);
        n_st.lx  = ra_ux[QW-1:0];
        n_st.ly  = ra_uy[QW-1:0];
        n_st.fx  = ra_fx;
        n_st.fy  = ra_fy;
        n_st.ovf = (DW'(ra_ux[NW-1:QW]) >= ra_ud) || (DW'(ra_uy[NW-1:QW]) >= ra_ud);
        n_st.box = ra_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
        end else if (i_en) begin
            ra_vld <= i_vld;
            rb_vld <= ra_vld;
            rc_vld <= w_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_ux   <= n_ux;
            ra_uy   <= n_uy;
            ra_ud   <= n_ud;
            ra_fx   <= i_num.nx[NW-1] ^ i_num.den[DW-1];
            ra_fy   <= i_num.ny[NW-1] ^ i_num.den[DW-1];
            ra_box  <= i_num.box;
            rb_st   <= n_st;
            rc_quot <= n_quot;
        end
    end

    assign w_vld[0] = rb_vld;
    assign w_st[0]  = rb_st;

    for (genvar k = 0; k < QW; k++) begin : g_step
        segi_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_vld[k]),
            .i_st    (w_st[k]),
            .o_vld   (w_vld[k+1]),
            .o_st    (w_st[k+1])
        );
    end

    always_comb begin
        n_quot.px  = w_st[QW].fx ? -$signed({1'b0, w_st[QW].qx})
                                 :  $signed({1'b0, w_st[QW].qx});
        n_quot.py  = w_st[QW].fy ? -$signed({1'b0, w_st[QW].qy})
                                 :  $signed({1'b0, w_st[QW].qy});
        n_quot.ovf = w_st[QW].ovf;
        n_quot.box = w_st[QW].box;
    end

    assign o_vld  = rc_vld;
    assign o_quot = rc_quot;

endmodule

// ----- src/segment_intersection_integer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_integer_core
// Integer line segment intersection, one pair per cycle while o_in_ready.
//
//   channel   direction   handshake                     payload
//   in        sink        i_in_valid / o_in_ready       i_in  (t_seg_in)
//   out       source      o_out_valid / i_out_ready     o_out (t_seg_out)
//
// An input beat passes through 4 product stages, 1 magnitude, 1 divider
// setup, 17 restoring steps, 1 sign stage and the output register on its
// way to its output beat. The restoring divider, one quotient bit per stage,
// sets the depth. One beat is taken per cycle while o_in_ready is high.
// Reset clears the valid bits only; data registers are not reset.
// A stalled output keeps its beat while one more lands in a skid slot;
// with the skid slot full the whole pipeline holds and o_in_ready is low.
// ----------------------------------------------------------------------------
module segment_intersection_integer_core
    import segi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_seg_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_seg_out o_out
);

    localparam int XW = QW + 1;

    logic     w_en;
    logic     w_num_vld;
    t_num     w_num;
    logic     w_quot_vld;
    t_quot    w_quot;

    logic     n_hit;
    t_seg_out n_out;
    logic     w_push;
    logic     w_take;

    logic     r_out_vld;
    t_seg_out r_out;
    logic     r_skd_vld;
    t_seg_out r_skd;

    assign w_en       = !r_skd_vld;
    assign o_in_ready = w_en;

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_seg   (i_in),
        .o_vld   (w_num_vld),
        .o_num   (w_num)
    );

    segi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_num_vld),
        .i_num   (w_num),
        .o_vld   (w_quot_vld),
        .o_quot  (w_quot)
    );

    // point must sit inside the overlap of both boxes
    assign n_hit = !w_quot.ovf
                && (w_quot.px >= XW'(w_quot.box.lox))
                && (w_quot.px <= XW'(w_quot.box.hix))
                && (w_quot.py >= XW'(w_quot.box.loy))
                && (w_quot.py <= XW'(w_quot.box.hiy));

    always_comb begin
        n_out.hit   = n_hit;
        n_out.hit_x = n_hit ? w_quot.px[CW-1:0] : '0;
        n_out.hit_y = n_hit ? w_quot.py[CW-1:0] : '0;
    end

    assign w_push = w_quot_vld && w_en;
    assign w_take = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= r_skd_vld || w_push;
            r_skd_vld <= 1'b0;
        end else if (w_push) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skd_vld ? r_skd : n_out;
        end else if (w_push) begin
            r_skd <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_skd_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid slot holds a beat while the output register is empty");

    a_skd_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_vld && !i_out_ready) |=> (r_skd_vld && $stable(r_skd)))
        else $error("skid beat lost or changed during an output stall");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.hit) |-> (r_out.hit_x == '0 && r_out.hit_y == '0))
        else $error("miss beat carries nonzero coordinates");
`endif

endmodule
